>>> rtl/pfcp_pkg.sv
// Shared types, type codes and length lookup for the packet filter component parser.
package pfcp_pkg;

  localparam int MAX_COMPONENTS = 16;
  localparam int CNT_W          = $clog2(MAX_COMPONENTS + 1);
  localparam int QDEPTH         = 2;

  // Component type codes
  localparam logic [7:0] TC_MATCH_ALL  = 8'h01;
  localparam logic [7:0] TC_V4_REMOTE  = 8'h10;
  localparam logic [7:0] TC_V4_LOCAL   = 8'h11;
  localparam logic [7:0] TC_V6_REMOTE  = 8'h21;
  localparam logic [7:0] TC_V6_LOCAL   = 8'h23;
  localparam logic [7:0] TC_PROTOCOL   = 8'h30;
  localparam logic [7:0] TC_LPORT      = 8'h40;
  localparam logic [7:0] TC_LPORT_RNG  = 8'h41;
  localparam logic [7:0] TC_RPORT      = 8'h50;
  localparam logic [7:0] TC_RPORT_RNG  = 8'h51;
  localparam logic [7:0] TC_SPI        = 8'h60;
  localparam logic [7:0] TC_TOS        = 8'h70;
  localparam logic [7:0] TC_FLOW_LABEL = 8'h80;
  localparam logic [7:0] TC_MAC_DST    = 8'h81;
  localparam logic [7:0] TC_MAC_SRC    = 8'h82;
  localparam logic [7:0] TC_VLAN_C     = 8'h83;
  localparam logic [7:0] TC_VLAN_S     = 8'h84;
  localparam logic [7:0] TC_ETHERTYPE  = 8'h87;

  localparam logic [63:0] FLOW_MASK = 64'h0000_0000_000F_FFFF;
  localparam logic [63:0] VLAN_MASK = 64'h0000_0000_0000_0FFF;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TRUNC   = 2'd1,
    ST_UNKNOWN = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_CLEAR  = 2'd1,
    ACT_SHIFT  = 2'd2,
    ACT_PREFIX = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    REP_NONE    = 2'd0,
    REP_DONE    = 2'd1,
    REP_TRUNC   = 2'd2,
    REP_UNKNOWN = 2'd3
  } rep_t;

  // One classified byte, handed from front to back
  typedef struct packed {
    act_t       act;
    rep_t       rep;
    logic       fin;
    logic [7:0] data;
    logic [7:0] ctype;
    logic [3:0] index;
    logic [7:0] used;
  } op_t;

  typedef struct packed {
    logic       known;
    logic [4:0] len;
  } len_t;

  function automatic len_t comp_len(input logic [7:0] t);
    len_t r;
    r.known = 1'b1;
    r.len   = 5'd0;
    unique case (t)
      TC_MATCH_ALL:                  r.len = 5'd0;
      TC_V4_REMOTE, TC_V4_LOCAL:     r.len = 5'd8;
      TC_V6_REMOTE, TC_V6_LOCAL:     r.len = 5'd17;
      TC_PROTOCOL:                   r.len = 5'd1;
      TC_LPORT, TC_RPORT, TC_VLAN_C,
      TC_VLAN_S, TC_TOS, TC_ETHERTYPE: r.len = 5'd2;
      TC_LPORT_RNG, TC_RPORT_RNG,
      TC_SPI, TC_FLOW_LABEL:         r.len = 5'd4;
      TC_MAC_DST, TC_MAC_SRC:        r.len = 5'd6;
      default:                       r.known = 1'b0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/pfcp_front.sv
// Front end: track component framing per byte and classify each byte into an op.
module pfcp_front import pfcp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] data_byte,
  input  logic       last,
  output op_t        op
);

  typedef enum logic [2:0] {
    M_TYPE  = 3'b001,
    M_VALUE = 3'b010,
    M_DRAIN = 3'b100
  } mode_t;

  mode_t            mode, mode_next;
  logic [7:0]       ctype, ctype_next;
  logic [4:0]       needed, needed_next;
  logic [CNT_W-1:0] count, count_next;
  logic [7:0]       byte_count, byte_count_next;

  logic [7:0]       bc_inc;
  logic [CNT_W-1:0] cnt_inc;
  logic             done_final;
  logic [4:0]       need_dec;
  len_t             lk;
  logic             is_v6;

  always_comb begin
    bc_inc     = (byte_count != 8'hFF) ? byte_count + 8'd1 : byte_count;
    cnt_inc    = count + CNT_W'(1);
    done_final = last || (cnt_inc >= CNT_W'(MAX_COMPONENTS));
    need_dec   = needed - 5'd1;
    lk         = comp_len(data_byte);
    is_v6      = (ctype == TC_V6_REMOTE) || (ctype == TC_V6_LOCAL);

    op.act   = ACT_NONE;
    op.rep   = REP_NONE;
    op.fin   = 1'b0;
    op.data  = data_byte;
    op.ctype = ctype;
    op.index = 4'(count);
    op.used  = bc_inc;

    mode_next       = mode;
    ctype_next      = ctype;
    needed_next     = needed;
    count_next      = count;
    byte_count_next = bc_inc;

    unique case (mode)
      M_TYPE: begin
        op.act     = ACT_CLEAR;
        op.ctype   = data_byte;
        ctype_next = data_byte;
        if (!lk.known) begin
          op.rep = REP_UNKNOWN;
          op.fin = 1'b1;
          mode_next = M_DRAIN;
        end else if (lk.len == 5'd0) begin
          op.rep     = REP_DONE;
          op.fin     = done_final;
          count_next = cnt_inc;
          mode_next  = done_final ? M_DRAIN : M_TYPE;
        end else begin
          needed_next = lk.len;
          mode_next   = M_VALUE;
          if (last) begin
            op.rep = REP_TRUNC;
            op.fin = 1'b1;
          end
        end
      end
      M_VALUE: begin
        if (is_v6 && needed == 5'd1) begin
          op.act = ACT_PREFIX;
        end else if (ctype == TC_ETHERTYPE) begin
          op.act = ACT_NONE;
        end else if (ctype == TC_TOS && needed == 5'd1) begin
          op.act = ACT_NONE;
        end else begin
          op.act = ACT_SHIFT;
        end
        needed_next = need_dec;
        if (need_dec == 5'd0) begin
          op.rep     = REP_DONE;
          op.fin     = done_final;
          count_next = cnt_inc;
          mode_next  = done_final ? M_DRAIN : M_TYPE;
        end else if (last) begin
          op.rep = REP_TRUNC;
          op.fin = 1'b1;
        end
      end
      M_DRAIN: begin
        op.act = ACT_NONE;
      end
      default: begin
        mode_next = M_TYPE;
      end
    endcase

    // End of filter: start over with all counts cleared
    if (last && (op.fin || mode == M_DRAIN)) begin
      mode_next       = M_TYPE;
      ctype_next      = 8'd0;
      needed_next     = 5'd0;
      count_next      = '0;
      byte_count_next = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_TYPE;
      ctype      <= 8'd0;
      needed     <= 5'd0;
      count      <= '0;
      byte_count <= 8'd0;
    end else if (fire) begin
      mode       <= mode_next;
      ctype      <= ctype_next;
      needed     <= needed_next;
      count      <= count_next;
      byte_count <= byte_count_next;
    end
  end

  a_drain_silent: assert property (@(posedge clk) disable iff (rst)
    (fire && mode == M_DRAIN) |-> (op.rep == REP_NONE))
    else $error("front reported while dropping bytes");

  a_value_needs_bytes: assert property (@(posedge clk) disable iff (rst)
    (mode == M_VALUE) |-> (needed != 5'd0))
    else $error("value mode with no bytes outstanding");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_COMPONENTS))
    else $error("component count beyond limit");

endmodule

>>> rtl/pfcp_queue.sv
// Small register queue of classified ops between front and back.
module pfcp_queue import pfcp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  op_t  push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output op_t  pop_data
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW    = $clog2(QDEPTH + 1);

  op_t              entries [QDEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push, do_pop;

  assign push_ready = (count != CW'(QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

>>> rtl/pfcp_back.sv
// Back end: assemble component values and hold the result register.
module pfcp_back import pfcp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        op_valid,
  output logic        op_ready,
  input  op_t         op,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [7:0]  comp_type,
  output logic [3:0]  comp_index,
  output logic [63:0] value_high,
  output logic [63:0] value_low,
  output logic [7:0]  v6_prefix,
  output logic [7:0]  bytes_used,
  output logic        final_res
);

  logic [63:0] vs_hi, vs_lo, vs_hi_next, vs_lo_next;
  logic [7:0]  prefix, prefix_next;
  logic [63:0] lo_masked;
  logic        take, load;

  assign op_ready = (op.rep == REP_NONE) || !out_valid || out_ready;
  assign take     = op_valid && op_ready;
  assign load     = take && (op.rep != REP_NONE);

  always_comb begin
    vs_hi_next  = vs_hi;
    vs_lo_next  = vs_lo;
    prefix_next = prefix;
    unique case (op.act)
      ACT_CLEAR: begin
        vs_hi_next  = 64'd0;
        vs_lo_next  = 64'd0;
        prefix_next = 8'd0;
      end
      ACT_SHIFT: begin
        vs_hi_next = {vs_hi[55:0], vs_lo[63:56]};
        vs_lo_next = {vs_lo[55:0], op.data};
      end
      ACT_PREFIX: prefix_next = op.data;
      ACT_NONE:   ;
      default:    ;
    endcase

    if (op.ctype == TC_FLOW_LABEL) begin
      lo_masked = vs_lo_next & FLOW_MASK;
    end else if (op.ctype == TC_VLAN_C || op.ctype == TC_VLAN_S) begin
      lo_masked = vs_lo_next & VLAN_MASK;
    end else begin
      lo_masked = vs_lo_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      vs_hi  <= vs_hi_next;
      vs_lo  <= vs_lo_next;
      prefix <= prefix_next;
    end
    if (load) begin
      comp_type  <= op.ctype;
      comp_index <= op.index;
      bytes_used <= op.used;
      final_res  <= op.fin;
      if (op.rep == REP_DONE) begin
        status     <= ST_OK;
        value_high <= vs_hi_next;
        value_low  <= lo_masked;
        v6_prefix  <= prefix_next;
      end else begin
        status     <= (op.rep == REP_TRUNC) ? ST_TRUNC : ST_UNKNOWN;
        value_high <= 64'd0;
        value_low  <= 64'd0;
        v6_prefix  <= 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |->
      (value_high == 64'd0 && value_low == 64'd0 && v6_prefix == 8'd0))
    else $error("error result carries value bits");

  a_error_final: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !final_res) |-> (status == ST_OK))
    else $error("error result not marked final");

endmodule

>>> rtl/packet_filter_component_parser_top.sv
// Top level of the packet filter component parser: front, op queue and back.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   data_byte, last
//   out      output     out_valid / out_ready status, comp_type, comp_index,
//                                             value_high, value_low, v6_prefix,
//                                             bytes_used, final_res
//
// One octet is taken per clock while in_ready is high; the front classifies it in
// the accept cycle and the op is written to the two-entry queue at that edge. The
// back takes it from the queue head when op_ready is high and loads the result, if
// any, into the output register, which raises out_valid until out_ready takes it.
// Reset (rst, synchronous) puts the parser at the type octet of a new filter.
// A stalled output holds its transaction; ops without a result still drain past it,
// and once an op with a result waits at the head of the queue, one more octet is
// taken before in_ready drops. Ops with no result leave the head without out_ready.
module packet_filter_component_parser_top import pfcp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [7:0]  comp_type,
  output logic [3:0]  comp_index,
  output logic [63:0] value_high,
  output logic [63:0] value_low,
  output logic [7:0]  v6_prefix,
  output logic [7:0]  bytes_used,
  output logic        final_res
);

  op_t  front_op;
  op_t  back_op;
  logic q_valid;
  logic q_ready;
  logic in_fire;

  assign in_fire = in_valid && in_ready;

  // Classify the accepted octet and advance framing state
  pfcp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .fire      (in_fire),
    .data_byte (data_byte),
    .last      (last),
    .op        (front_op)
  );

  // Decouple classification from value assembly and result delivery
  pfcp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  (front_op),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (back_op)
  );

  // Assemble values and drive the result transaction
  pfcp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .op_valid   (q_valid),
    .op_ready   (q_ready),
    .op         (back_op),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .comp_type  (comp_type),
    .comp_index (comp_index),
    .value_high (value_high),
    .value_low  (value_low),
    .v6_prefix  (v6_prefix),
    .bytes_used (bytes_used),
    .final_res  (final_res)
  );

endmodule
